[rtl/kbhp_pkg.sv]
// ----------------------------------------------------------------------------
// kbhp_pkg
// Types and constants shared by the key blob header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package kbhp_pkg;

    // Input beat: one blob byte and its end marker
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_beat;

    // Output beat: byte passed through with its tag and verdict
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] section;
        logic [1:0] error_code;
        logic       blob_end;
        logic       blob_ok;
    } t_out_beat;

    // Parser phases
    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_MODULUS  = 2'd1;
    localparam logic [1:0] PH_EXPONENT = 2'd2;
    localparam logic [1:0] PH_DONE     = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_FORMAT  = 2'd1;
    localparam logic [1:0] ERR_VERSION = 2'd2;
    localparam logic [1:0] ERR_TYPE    = 2'd3;

    // Section tags
    localparam logic [1:0] SEC_HEADER   = 2'd0;
    localparam logic [1:0] SEC_MODULUS  = 2'd1;
    localparam logic [1:0] SEC_EXPONENT = 2'd2;
    localparam logic [1:0] SEC_IGNORED  = 2'd3;

    // Header byte positions
    localparam logic [3:0] HDR_VERSION_IDX = 4'd4;
    localparam logic [3:0] HDR_TYPE_IDX    = 4'd5;
    localparam logic [3:0] HDR_MLEN_IDX    = 4'd6;
    localparam logic [3:0] HDR_ELEN_IDX    = 4'd10;
    localparam logic [3:0] HDR_LAST_IDX    = 4'd13;

    // Magic "SWKY", byte 0 in the low lane
    localparam logic [31:0] MAGIC_WORD   = 32'h594B_5753;
    localparam logic [7:0]  VERSION_BYTE = 8'h01;

    // Config register map
    localparam int          PADDR_W          = 3;
    localparam logic        REG_KEY_TYPE_SEL = 1'b0;
    localparam logic [1:0]  KEY_TYPE_RESET   = 2'd1;

endpackage : kbhp_pkg

`default_nettype wire

[rtl/key_blob_header_parser_top.sv]
// An accepted input beat goes to the result register, or to the skid entry
//   while that is held. Throughput: one byte per cycle while o_stall is low;
//   next state decrements and compares the 32-bit remaining-byte counter.
// A two-entry output buffer (result register plus skid) keeps input open
//   while one result waits. Reset: parser in header phase, no error,
//   key type register = 1, both output entries empty.
// ----------------------------------------------------------------------------
// key_blob_header_parser_top
// Checks a key blob byte by byte (magic, version, type, lengths, nonzero
// values, total size) and tags each byte with its section and sticky error.
// ----------------------------------------------------------------------------
`default_nettype none

module key_blob_header_parser_top
    import kbhp_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // input channel
    input  wire                      i_valid,
    input  wire  t_in_beat           i_data,
    output logic                     o_stall,
    // output channel
    output logic                     o_valid,
    output t_out_beat                o_data,
    input  wire                      i_stall,
    // config port
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire  [PADDR_W-1:0]       paddr,
    input  wire  [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // parser state
    logic [1:0]  r_phase,   n_phase;
    logic [3:0]  r_hdr_idx, n_hdr_idx;
    logic [31:0] r_mod_len, n_mod_len;
    logic [31:0] r_exp_len, n_exp_len;
    logic [31:0] r_remain,  n_remain;
    logic        r_nz_seen, n_nz_seen;
    logic [1:0]  r_err,     n_err;
    logic [1:0]  r_key_type;

    // output buffer
    logic        r_out_v;
    t_out_beat   r_out;
    logic        r_skid_v;
    t_out_beat   r_skid;

    logic        in_acc;
    logic        out_take;
    t_out_beat   res;
    logic [1:0]  sec;
    logic [1:0]  lane;
    logic [7:0]  b;
    logic        last;

    assign b        = i_data.in_byte;
    assign last     = i_data.is_last;
    assign o_stall  = r_skid_v;
    assign in_acc   = i_valid && !r_skid_v;
    assign out_take = r_out_v && !i_stall;
    assign o_valid  = r_out_v;
    assign o_data   = r_out;

    // length byte lane: positions 6..9 and 10..13 map to lanes 0..3
    assign lane = 2'(r_hdr_idx[1:0] + 2'd2);

    // config register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_type <= KEY_TYPE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_KEY_TYPE_SEL) begin
            r_key_type <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_KEY_TYPE_SEL) begin
            prdata = {30'd0, r_key_type};
        end
    end

    // next state and result for the byte at the input
    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_mod_len = r_mod_len;
        n_exp_len = r_exp_len;
        n_remain  = r_remain;
        n_nz_seen = r_nz_seen;
        n_err     = r_err;
        sec       = SEC_IGNORED;

        if (r_err == ERR_NONE) begin
            case (r_phase)
                PH_HEADER: begin
                    sec = SEC_HEADER;
                    // field checks and length capture
                    if (r_hdr_idx < HDR_VERSION_IDX) begin
                        if (b != MAGIC_WORD[{r_hdr_idx[1:0], 3'b000} +: 8]) begin
                            n_err = ERR_FORMAT;
                        end
                    end else if (r_hdr_idx == HDR_VERSION_IDX) begin
                        if (b != VERSION_BYTE) begin
                            n_err = ERR_VERSION;
                        end
                    end else if (r_hdr_idx == HDR_TYPE_IDX) begin
                        if (b != {6'd0, r_key_type}) begin
                            n_err = ERR_TYPE;
                        end
                    end else if (r_hdr_idx < HDR_ELEN_IDX) begin
                        n_mod_len[{lane, 3'b000} +: 8] = b;
                    end else if (r_hdr_idx <= HDR_LAST_IDX) begin
                        n_exp_len[{lane, 3'b000} +: 8] = b;
                    end
                    // advance
                    if (last) begin
                        n_err = ERR_FORMAT;
                    end else if (r_hdr_idx >= HDR_LAST_IDX) begin
                        if (n_mod_len == '0 || n_exp_len == '0) begin
                            if (n_err == ERR_NONE) begin
                                n_err = ERR_FORMAT;
                            end
                        end else begin
                            n_phase   = PH_MODULUS;
                            n_remain  = n_mod_len;
                            n_nz_seen = 1'b0;
                        end
                    end else begin
                        n_hdr_idx = r_hdr_idx + 4'd1;
                    end
                end
                PH_MODULUS, PH_EXPONENT: begin
                    sec       = (r_phase == PH_MODULUS) ? SEC_MODULUS : SEC_EXPONENT;
                    n_nz_seen = r_nz_seen || (b != 8'd0);
                    if (r_remain != '0) begin
                        n_remain = r_remain - 32'd1;
                    end
                    if (n_remain == '0) begin
                        if (!n_nz_seen) begin
                            n_err = ERR_FORMAT;
                        end else if (r_phase == PH_MODULUS) begin
                            n_phase   = PH_EXPONENT;
                            n_remain  = r_exp_len;
                            n_nz_seen = 1'b0;
                            if (last) begin
                                n_err = ERR_FORMAT;
                            end
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end else if (last) begin
                        n_err = ERR_FORMAT;
                    end
                end
                default: begin
                    // bytes beyond the exponent
                    sec   = SEC_IGNORED;
                    n_err = ERR_FORMAT;
                end
            endcase
        end

        res.out_byte   = b;
        res.section    = sec;
        res.error_code = n_err;
        res.blob_end   = last;
        res.blob_ok    = last && (n_err == ERR_NONE) && (n_phase == PH_DONE);

        // end of blob returns the parser to its reset state
        if (last) begin
            n_phase   = PH_HEADER;
            n_hdr_idx = '0;
            n_mod_len = '0;
            n_exp_len = '0;
            n_remain  = '0;
            n_nz_seen = 1'b0;
            n_err     = ERR_NONE;
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_idx <= '0;
            r_mod_len <= '0;
            r_exp_len <= '0;
            r_remain  <= '0;
            r_nz_seen <= 1'b0;
            r_err     <= ERR_NONE;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_mod_len <= n_mod_len;
            r_exp_len <= n_exp_len;
            r_remain  <= n_remain;
            r_nz_seen <= n_nz_seen;
            r_err     <= n_err;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || out_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || out_take) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= res;
            end
        end else if (in_acc) begin
            r_skid <= res;
        end
    end

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while output register empty");

    a_ok_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.blob_ok) |-> (o_data.blob_end && o_data.error_code == ERR_NONE))
        else $error("blob_ok without clean blob end");

    a_ignored_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.section == SEC_IGNORED) |-> (o_data.error_code != ERR_NONE))
        else $error("ignored section without error");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.is_last) |=>
            (r_phase == PH_HEADER && r_hdr_idx == '0 && r_err == ERR_NONE))
        else $error("parser not cleared after last byte");

endmodule : key_blob_header_parser_top

`default_nettype wire

[test/key_blob_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_blob_checker
// Watches both beat channels and the config port of the key blob parser.
// Keeps its own copy of the parser state, works out the tag of every
// accepted input byte and compares each output beat against the oldest
// pending tag. Hands the failure count and the pending depth to the bench.
// ----------------------------------------------------------------------------

module key_blob_checker
    import kbhp_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input channel as seen at the block
    input  wire                 i_in_valid,
    input  t_in_beat            i_in_data,
    input  wire                 i_in_stall,
    // output channel as seen at the block
    input  wire                 i_out_valid,
    input  t_out_beat           i_out_data,
    input  wire                 i_out_stall,
    // config port
    input  wire                 i_psel,
    input  wire                 i_penable,
    input  wire                 i_pwrite,
    input  wire                 i_pready,
    input  wire [PADDR_W-1:0]   i_paddr,
    input  wire [31:0]          i_pwdata,
    // status to the bench
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_good_blobs
);

    localparam logic [PADDR_W-1:0] KEY_TYPE_ADDR = {REG_KEY_TYPE_SEL, 2'b00};
    localparam int                 MAX_SHOWN     = 10;

    // Parser copy
    logic [1:0]  key_type;
    logic [1:0]  phase;
    logic [3:0]  hdr_idx;
    logic [31:0] mod_len;
    logic [31:0] exp_len;
    logic [31:0] remaining;
    logic        nonzero;
    logic [1:0]  sticky;

    t_out_beat   tag_queue[$];
    t_out_beat   want;
    int          fail_cnt  = 0;
    int          good_cnt  = 0;

    function automatic void clear_parser();
        phase     = PH_HEADER;
        hdr_idx   = '0;
        mod_len   = '0;
        exp_len   = '0;
        remaining = '0;
        nonzero   = 1'b0;
        sticky    = ERR_NONE;
    endfunction

    // Only the first error of a blob sticks
    function automatic void flag_error(logic [1:0] code);
        if (sticky == ERR_NONE) begin
            sticky = code;
        end
    endfunction

    // Tag one byte and advance the parser copy
    function automatic t_out_beat tag_byte(t_in_beat beat);
        t_out_beat  res;
        logic [7:0] b;
        logic [3:0] idx;
        b            = beat.in_byte;
        idx          = hdr_idx;
        res.out_byte = b;
        res.section  = SEC_IGNORED;
        if (sticky != ERR_NONE) begin
            res.section = SEC_IGNORED;
        end else if (phase == PH_HEADER) begin
            res.section = SEC_HEADER;
            if (idx < HDR_VERSION_IDX) begin
                if (b != MAGIC_WORD[8*idx +: 8]) flag_error(ERR_FORMAT);
            end else if (idx == HDR_VERSION_IDX) begin
                if (b != VERSION_BYTE) flag_error(ERR_VERSION);
            end else if (idx == HDR_TYPE_IDX) begin
                if (b != {6'd0, key_type}) flag_error(ERR_TYPE);
            end else if (idx < HDR_ELEN_IDX) begin
                mod_len[8*(idx - HDR_MLEN_IDX) +: 8] = b;
            end else if (idx <= HDR_LAST_IDX) begin
                exp_len[8*(idx - HDR_ELEN_IDX) +: 8] = b;
            end
            // a last byte in the header always means a short blob
            if (beat.is_last) begin
                sticky = ERR_FORMAT;
            end else if (idx >= HDR_LAST_IDX) begin
                if (mod_len == 0 || exp_len == 0) begin
                    flag_error(ERR_FORMAT);
                end else begin
                    phase     = PH_MODULUS;
                    remaining = mod_len;
                    nonzero   = 1'b0;
                end
            end else begin
                hdr_idx = idx + 4'd1;
            end
        end else if (phase == PH_MODULUS || phase == PH_EXPONENT) begin
            res.section = (phase == PH_MODULUS) ? SEC_MODULUS : SEC_EXPONENT;
            if (b != 8'd0) nonzero = 1'b1;
            if (remaining != 0) remaining = remaining - 1;
            if (remaining == 0) begin
                if (!nonzero) begin
                    flag_error(ERR_FORMAT);
                end else if (phase == PH_MODULUS) begin
                    phase     = PH_EXPONENT;
                    remaining = exp_len;
                    nonzero   = 1'b0;
                    if (beat.is_last) flag_error(ERR_FORMAT);
                end else begin
                    phase = PH_DONE;
                end
            end else if (beat.is_last) begin
                flag_error(ERR_FORMAT);
            end
        end else begin
            // trailing bytes past the exponent
            flag_error(ERR_FORMAT);
        end
        res.error_code = sticky;
        res.blob_end   = beat.is_last;
        res.blob_ok    = beat.is_last && (sticky == ERR_NONE) && (phase == PH_DONE);
        if (beat.is_last) clear_parser();
        return res;
    endfunction

    function automatic void report(string why, t_out_beat exp_b, t_out_beat got);
        fail_cnt++;
        if (fail_cnt <= MAX_SHOWN) begin
            $display("[%0t] %s: got byte %02h sec %0d err %0d end %0b ok %0b",
                     $time, why, got.out_byte, got.section, got.error_code,
                     got.blob_end, got.blob_ok);
            $display("        expected byte %02h sec %0d err %0d end %0b ok %0b",
                     exp_b.out_byte, exp_b.section, exp_b.error_code,
                     exp_b.blob_end, exp_b.blob_ok);
        end
    endfunction

    // Predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_type = KEY_TYPE_RESET;
            clear_parser();
            tag_queue.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                tag_queue.insert(tag_queue.size(), tag_byte(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (i_out_data.blob_end && i_out_data.blob_ok) good_cnt++;
                if (tag_queue.size() == 0) begin
                    report("output beat with nothing pending", '0, i_out_data);
                end else begin
                    want = tag_queue.pop_front();
                    if (want.out_byte   !== i_out_data.out_byte   ||
                        want.section    !== i_out_data.section    ||
                        want.error_code !== i_out_data.error_code ||
                        want.blob_end   !== i_out_data.blob_end   ||
                        want.blob_ok    !== i_out_data.blob_ok) begin
                        report("output beat mismatch", want, i_out_data);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == KEY_TYPE_ADDR) begin
                key_type = i_pwdata[1:0];
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= tag_queue.size();
        o_good_blobs <= good_cnt;
    end

endmodule

[test/tb_key_blob_header_parser_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_blob_header_parser_top
// Drives key blobs into the parser under bursty input and a random output
// stall pattern, steps the key type register through all four values and
// leaves prediction and comparison to key_blob_checker.
// ----------------------------------------------------------------------------

module tb_key_blob_header_parser_top;
    import kbhp_pkg::*;

    localparam logic [PADDR_W-1:0] KEY_TYPE_ADDR  = {REG_KEY_TYPE_SEL, 2'b00};
    localparam logic [1:0]         KEY_PUBLIC     = 2'd1;
    localparam logic [1:0]         KEY_PRIVATE    = 2'd2;
    localparam logic [1:0]         KEY_INVALID_LO = 2'd0;
    localparam logic [1:0]         KEY_INVALID_HI = 2'd3;
    localparam int NUM_SETTINGS   = 5;
    localparam int SETTING_BYTES  = 330;
    localparam int LATENCY_PAD    = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_AT    = 700;
    localparam int PRESSURE_HOLD  = 80;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    t_in_beat            i_data;
    logic                o_stall;
    logic                o_valid;
    t_out_beat           o_data;
    logic                i_stall;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  good_blobs;

    logic [7:0]          blob_bytes[$];
    logic [1:0]          key_type_now  = KEY_TYPE_RESET;
    int                  burst_left    = 0;
    int                  bytes_sent    = 0;
    int                  blobs_sent    = 0;
    int                  idle_cycles   = 0;
    logic                pressure_done = 1'b0;

    key_blob_header_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    key_blob_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_data    (i_data),
        .i_in_stall   (o_stall),
        .i_out_valid  (o_valid),
        .i_out_data   (o_data),
        .i_out_stall  (i_stall),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_good_blobs (good_blobs)
    );

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output stall pattern, with one long hold-off to back up the block
    initial begin : stall_pattern
        int mode;
        int span;
        int hold;
        i_stall <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 64);
            repeat (span) begin
                @(posedge i_clk);
                if (!pressure_done && bytes_sent >= PRESSURE_AT) begin
                    i_stall <= 1'b1;
                    for (hold = 0; hold < PRESSURE_HOLD; hold++) @(posedge i_clk);
                    pressure_done = 1'b1;
                end
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // One input beat, with burst/gap shaping in front of it
    task automatic send_beat(input t_in_beat beat);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_blob();
        t_in_beat beat;
        for (int i = 0; i < blob_bytes.size(); i++) begin
            beat.in_byte = blob_bytes[i];
            beat.is_last = (i == blob_bytes.size() - 1);
            send_beat(beat);
        end
        blobs_sent++;
    endtask

    // Append one byte to the blob under construction
    task automatic add_byte(input logic [7:0] value);
        blob_bytes.insert(blob_bytes.size(), value);
    endtask

    task automatic push_header(input logic [7:0] ktype, input logic [31:0] mlen,
                               input logic [31:0] elen);
        for (int k = 0; k < 4; k++) add_byte(MAGIC_WORD[8*k +: 8]);
        add_byte(VERSION_BYTE);
        add_byte(ktype);
        for (int k = 0; k < 4; k++) add_byte(mlen[8*k +: 8]);
        for (int k = 0; k < 4; k++) add_byte(elen[8*k +: 8]);
    endtask

    task automatic cut_blob(input int keep);
        while (blob_bytes.size() > keep) void'(blob_bytes.pop_back());
    endtask

    // Well-formed blobs with random payload, nearly half with one defect,
    // some plain noise
    task automatic make_blob();
        int kind;
        int mlen;
        int elen;
        int n;
        kind = $urandom_range(0, 99);
        blob_bytes.delete();
        if (kind < 12) begin
            n = $urandom_range(1, 24);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        mlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        elen = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        push_header({6'd0, key_type_now}, mlen, elen);
        repeat (mlen + elen) add_byte(8'($urandom_range(0, 255)));
        // keep both values nonzero
        blob_bytes[14 + $urandom_range(0, mlen - 1)] = 8'($urandom_range(1, 255));
        blob_bytes[14 + mlen + $urandom_range(0, elen - 1)] = 8'($urandom_range(1, 255));
        if (kind < 60) begin
            case ($urandom_range(0, 9))
                0: blob_bytes[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                1: blob_bytes[HDR_VERSION_IDX] ^= 8'($urandom_range(1, 255));
                2: blob_bytes[HDR_TYPE_IDX] ^= 8'($urandom_range(1, 255));
                3: for (int k = 6; k < 10; k++) blob_bytes[k] = 8'h00;
                4: for (int k = 10; k < 14; k++) blob_bytes[k] = 8'h00;
                5: for (int k = 0; k < mlen; k++) blob_bytes[14 + k] = 8'h00;
                6: for (int k = 0; k < elen; k++) blob_bytes[14 + mlen + k] = 8'h00;
                7: cut_blob($urandom_range(1, blob_bytes.size() - 1));
                8: begin
                    n = $urandom_range(1, 4);
                    repeat (n) add_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    // huge random lengths, blob ends long before them
                    for (int k = 6; k < 14; k++) blob_bytes[k] = 8'($urandom_range(0, 255));
                    cut_blob($urandom_range(7, blob_bytes.size() - 1));
                end
            endcase
        end
    endtask

    // Short directed blobs: one minimal valid, one single byte, bad version
    task automatic run_directed();
        blob_bytes.delete();
        push_header({6'd0, key_type_now}, 32'd1, 32'd1);
        add_byte(8'hFF);
        add_byte(8'h80);
        send_blob();
        blob_bytes.delete();
        add_byte(8'h00);
        send_blob();
        blob_bytes.delete();
        push_header({6'd0, key_type_now}, 32'd1, 32'd1);
        blob_bytes[HDR_VERSION_IDX] = 8'h02;
        cut_blob(7);
        send_blob();
    endtask

    // Stop sending and wait until every output beat has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_key_type(input logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_TYPE_ADDR;
        pwdata  <= {30'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        key_type_now = value;
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        logic [1:0] plan [NUM_SETTINGS];
        int         start_bytes;
        plan = '{KEY_TYPE_RESET, KEY_PRIVATE, KEY_INVALID_LO, KEY_INVALID_HI, KEY_PUBLIC};
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s > 0) begin
                drain();
                write_key_type(plan[s]);
            end
            if (s == 0) run_directed();
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < SETTING_BYTES) begin
                make_blob();
                send_blob();
            end
        end
        drain();

        $display("Covered %0d bytes in %0d blobs under key type settings 1, 2, 0, 3, 1,",
                 bytes_sent, blobs_sent);
        $display("with bursty input, random output stalls and one long hold-off; %0d clean",
                 good_blobs);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("failures: %0d, beats never returned: %0d", fail_count, pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
